/* rtl/fir_filter_sliding_window_core_macros.svh */
// ----------------------------------------------------------------------------
// FIR sliding-window core: assertion macros
// Concurrent checks shared by the RTL; compiled away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_SLIDING_WINDOW_CORE_MACROS_SVH
`define FIR_FILTER_SLIDING_WINDOW_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsw check failed");

// next-cycle implication
`define FSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsw check failed");

`else

`define FSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/fsw_pkg.sv */
// ----------------------------------------------------------------------------
// FIR sliding-window core: package
// Widths, types and the control-state encoding shared by the core modules.
// ----------------------------------------------------------------------------
package fsw_pkg;

    localparam int TAP_COUNT  = 8;
    localparam int NUM_COEFS  = 8;
    localparam int TAP_IDX_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int COEF_IDX_W = $clog2(NUM_COEFS);
    localparam int CFG_IDX_W  = COEF_IDX_W + 1;
    localparam int FILL_W     = $clog2(TAP_COUNT) + 1;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int DIGIT_W    = 4;
    localparam int DIGITS     = SAMPLE_W / DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(DIGITS);
    localparam int PP_W       = COEF_W + DIGIT_W + 1;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = 35;
    localparam int OUT_TDATA_W = ((ACC_W + 7) / 8) * 8;

    typedef logic [TAP_COUNT-1:0][SAMPLE_W-1:0] win_t;
    typedef logic [TAP_COUNT-1:0][COEF_W-1:0]   tap_coef_t;

    // control from sequencer to MAC
    typedef struct packed {
        logic start;
    } fsw_ctrl_t;

    // status from MAC to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } fsw_stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_CALC,
        S_HOLD
    } fsw_state_t;

endpackage

/* rtl/fsw_window.sv */
// ----------------------------------------------------------------------------
// FIR sliding-window core: sample window
// Shift line of the last TAP_COUNT samples (entry 0 oldest) and fill count.
// ----------------------------------------------------------------------------
module fsw_window
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [fsw_pkg::SAMPLE_W-1:0]     sample,
    output fsw_pkg::win_t                    window,
    output logic                             full
);

    fsw_pkg::win_t                 win_reg;
    fsw_pkg::win_t                 win_next;
    logic [fsw_pkg::FILL_W-1:0]    fill_reg;
    logic [fsw_pkg::FILL_W-1:0]    fill_next;

    // window is full once TAP_COUNT-1 samples are held and one more arrives
    assign full = (fill_reg == fsw_pkg::FILL_W'(fsw_pkg::TAP_COUNT - 1));

    // shift in the newest sample at the top
    always_comb
    begin
        win_next = win_reg;
        if (push)
        begin
            for (int k = 0; k < fsw_pkg::TAP_COUNT - 1; k++)
            begin
                win_next[k] = win_reg[k + 1];
            end
            win_next[fsw_pkg::TAP_COUNT - 1] = sample;
        end
    end

    // fill count saturates at TAP_COUNT-1
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !full)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign window = win_reg;

endmodule

/* rtl/fsw_mac.sv */
// ----------------------------------------------------------------------------
// FIR sliding-window core: digit-serial multiply-accumulate
// Walks the taps; each product is built MSB digit first, 4 bits a cycle,
// then added into the 35-bit accumulator.
// ----------------------------------------------------------------------------
module fsw_mac
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  fsw_pkg::fsw_ctrl_t               ctrl,
    input  fsw_pkg::win_t                    window,
    input  fsw_pkg::tap_coef_t               coefs,
    output fsw_pkg::fsw_stat_t               stat,
    output logic signed [fsw_pkg::ACC_W-1:0] result
);

    logic                                  busy_reg,  busy_next;
    logic                                  add_reg,   add_next;
    logic                                  done_reg,  done_next;
    logic [fsw_pkg::TAP_IDX_W-1:0]         tap_reg,   tap_next;
    logic [fsw_pkg::DIG_CNT_W-1:0]         dig_reg,   dig_next;
    logic [fsw_pkg::SAMPLE_W-1:0]          samp_reg,  samp_next;
    logic signed [fsw_pkg::PROD_W-1:0]     prod_reg,  prod_next;
    logic signed [fsw_pkg::ACC_W-1:0]      acc_reg,   acc_next;

    logic [fsw_pkg::TAP_IDX_W-1:0]         tap_inc;
    logic [fsw_pkg::DIGIT_W-1:0]           digit;
    logic signed [fsw_pkg::DIGIT_W:0]      digit_s;
    logic signed [fsw_pkg::COEF_W-1:0]     coef_sel;
    logic signed [fsw_pkg::PP_W-1:0]       pp;
    logic                                  last_tap;

    assign tap_inc  = tap_reg + 1'b1;
    assign last_tap = (tap_reg == fsw_pkg::TAP_IDX_W'(fsw_pkg::TAP_COUNT - 1));

    // top digit of the sample carries the sign, the rest are unsigned
    assign digit    = samp_reg[fsw_pkg::SAMPLE_W-1 -: fsw_pkg::DIGIT_W];
    assign digit_s  = $signed({(dig_reg == '0) & digit[fsw_pkg::DIGIT_W-1], digit});
    assign coef_sel = $signed(coefs[tap_reg]);
    assign pp       = fsw_pkg::PP_W'(coef_sel) * fsw_pkg::PP_W'(digit_s);

    // sequencing: load tap, DIGITS digit steps, one accumulate step
    always_comb
    begin
        busy_next = busy_reg;
        add_next  = add_reg;
        done_next = 1'b0;
        tap_next  = tap_reg;
        dig_next  = dig_reg;
        samp_next = samp_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;

        if (ctrl.start)
        begin
            busy_next = 1'b1;
            add_next  = 1'b0;
            tap_next  = '0;
            dig_next  = '0;
            samp_next = window[0];
            prod_next = '0;
            acc_next  = '0;
        end
        else if (busy_reg && !add_reg)
        begin
            prod_next = (prod_reg <<< fsw_pkg::DIGIT_W) + fsw_pkg::PROD_W'(pp);
            samp_next = samp_reg << fsw_pkg::DIGIT_W;
            dig_next  = dig_reg + 1'b1;
            if (dig_reg == fsw_pkg::DIG_CNT_W'(fsw_pkg::DIGITS - 1))
            begin
                add_next = 1'b1;
            end
        end
        else if (busy_reg && add_reg)
        begin
            acc_next = acc_reg + fsw_pkg::ACC_W'(prod_reg);
            add_next = 1'b0;
            if (last_tap)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                tap_next  = tap_inc;
                dig_next  = '0;
                samp_next = window[tap_inc];
                prod_next = '0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            add_reg  <= 1'b0;
            done_reg <= 1'b0;
            tap_reg  <= '0;
            dig_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            add_reg  <= add_next;
            done_reg <= done_next;
            tap_reg  <= tap_next;
            dig_reg  <= dig_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;

endmodule

/* rtl/fir_filter_sliding_window_core.sv */
// A sample that completes the window gives its result through S_START and S_CALC of the
// sequencer and the output register: the digit-serial MAC spends four 4-bit digit
// steps and one accumulate step per tap. Samples that only fill the window start no MAC run.
// New samples wait until the result is loaded for output; the MAC is the single shared unit.
// Reset (rst_n, asynchronous, active low) clears coefficients to zero and empties the
// window; window contents are undefined until written.
// ----------------------------------------------------------------------------
// FIR sliding-window core: top level
// Direct-form FIR over the last TAP_COUNT samples, coefficient port,
// sequencer and output register.
// ----------------------------------------------------------------------------
`include "fir_filter_sliding_window_core_macros.svh"

module fir_filter_sliding_window_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fsw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fsw_pkg::COEF_W-1:0]           cfg_data,

    // sample input
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fsw_pkg::SAMPLE_W-1:0]         s_axis_tdata,   // [15:0] sample_in

    // filtered output
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [fsw_pkg::OUT_TDATA_W-1:0]      m_axis_tdata    // [34:0] filtered_out
);

    fsw_pkg::fsw_state_t                   state_reg, state_next;
    logic [fsw_pkg::NUM_COEFS-1:0][fsw_pkg::COEF_W-1:0] coef_reg;
    logic                                  out_valid_reg, out_valid_next;
    logic [fsw_pkg::ACC_W-1:0]             out_data_reg;

    fsw_pkg::fsw_ctrl_t                    mac_ctrl;
    fsw_pkg::fsw_stat_t                    mac_stat;
    fsw_pkg::win_t                         window;
    logic signed [fsw_pkg::ACC_W-1:0]      mac_result;
    logic                                  win_full;
    logic                                  in_xact;
    logic                                  out_free;
    logic                                  out_load;

    assign in_xact  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // coefficient registers; writes beyond the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_valid && (cfg_index < fsw_pkg::CFG_IDX_W'(fsw_pkg::NUM_COEFS)))
        begin
            coef_reg[cfg_index[fsw_pkg::COEF_IDX_W-1:0]] <= cfg_data;
        end
    end

    fsw_window u_window
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (in_xact),
        .sample (s_axis_tdata),
        .window (window),
        .full   (win_full)
    );

    fsw_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .window (window),
        .coefs  (coef_reg[fsw_pkg::TAP_COUNT-1:0]),
        .stat   (mac_stat),
        .result (mac_result)
    );

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fsw_pkg::S_IDLE:
            begin
                if (in_xact && win_full)
                begin
                    state_next = fsw_pkg::S_START;
                end
            end
            fsw_pkg::S_START:
            begin
                state_next = fsw_pkg::S_CALC;
            end
            fsw_pkg::S_CALC:
            begin
                if (mac_stat.done)
                begin
                    state_next = out_free ? fsw_pkg::S_IDLE : fsw_pkg::S_HOLD;
                end
            end
            fsw_pkg::S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = fsw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fsw_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        s_axis_tready  = 1'b0;
        mac_ctrl.start = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            fsw_pkg::S_IDLE:  s_axis_tready  = 1'b1;
            fsw_pkg::S_START: mac_ctrl.start = 1'b1;
            fsw_pkg::S_CALC:  out_load       = mac_stat.done && out_free;
            fsw_pkg::S_HOLD:  out_load       = out_free;
            default:          s_axis_tready  = 1'b0;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsw_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= mac_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = fsw_pkg::OUT_TDATA_W'(out_data_reg);

    // checks
    `FSW_ASSERT_IMP(a_idle_mac_quiet, clk, rst_n, state_reg == fsw_pkg::S_IDLE, !mac_stat.busy)
    `FSW_ASSERT_IMP(a_done_in_calc, clk, rst_n, mac_stat.done, state_reg == fsw_pkg::S_CALC)
    `FSW_ASSERT_NXT(a_partial_no_calc, clk, rst_n, in_xact && !win_full, state_reg == fsw_pkg::S_IDLE)
    `FSW_ASSERT_IMP(a_hold_needs_out, clk, rst_n, state_reg == fsw_pkg::S_HOLD, out_valid_reg)

endmodule

/* bench/fir_filter_sliding_window_core_tb.sv */
// ----------------------------------------------------------------------------
// FIR sliding-window core: self-checking testbench
// Streams Q0.15 samples into the core and checks each filtered sum against
// an in-bench model of the eight-tap window. Coefficients are rewritten
// between phases while the core is idle. Random gaps are inserted on the
// sample side and random stalls on the result side, and one long result
// stall fills the core so that it has to hold off its input.
// ----------------------------------------------------------------------------
module fir_filter_sliding_window_core_tb;

    // register map of the coefficient port
    typedef enum logic [fsw_pkg::CFG_IDX_W-1:0] {
        REG_COEF_0,
        REG_COEF_1,
        REG_COEF_2,
        REG_COEF_3,
        REG_COEF_4,
        REG_COEF_5,
        REG_COEF_6,
        REG_COEF_7
    } coef_reg_t;

    localparam logic [fsw_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO =
        fsw_pkg::CFG_IDX_W'(fsw_pkg::NUM_COEFS);
    localparam logic [fsw_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

    localparam logic signed [fsw_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [fsw_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [fsw_pkg::COEF_W-1:0]   COEF_MAX   = 16'sh7FFF;
    localparam logic signed [fsw_pkg::COEF_W-1:0]   COEF_MIN   = 16'sh8000;

    localparam int MAC_LATENCY  = 2 + 5 * fsw_pkg::TAP_COUNT;
    localparam int DRAIN_CYCLES = MAC_LATENCY + 20;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 500;
    localparam int PHASE_ITEMS  = 135;
    localparam int NUM_PHASES   = 6;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [fsw_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [fsw_pkg::COEF_W-1:0]        cfg_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [fsw_pkg::SAMPLE_W-1:0]      s_axis_tdata;     // [15:0] sample_in
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [fsw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;     // [34:0] filtered_out

    // bench copy of the filter state
    logic signed [fsw_pkg::COEF_W-1:0]   tap_coef [fsw_pkg::NUM_COEFS];
    logic signed [fsw_pkg::SAMPLE_W-1:0] sample_hist [fsw_pkg::TAP_COUNT];
    int                                  samples_held = 0;
    logic signed [fsw_pkg::ACC_W-1:0]    pending_sums [$];

    int  error_count   = 0;
    int  sent_count    = 0;
    int  checked_count = 0;
    int  cfg_writes    = 0;
    int  idle_cycles   = 0;
    int  rx_stall_left = 0;
    bit  no_idle       = 1'b0;

    fir_filter_sliding_window_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter model: store the sample, and once the window is full give
    // the exact sum of products (tap 0 on the oldest) and slide by one.
    // ------------------------------------------------------------------
    function automatic void compute_fir_sum(input logic signed [fsw_pkg::SAMPLE_W-1:0] x);
        logic signed [fsw_pkg::ACC_W-1:0] acc;
        int i;
        if (samples_held >= fsw_pkg::TAP_COUNT)
            samples_held = 0;
        sample_hist[samples_held] = x;
        samples_held++;
        if (samples_held < fsw_pkg::TAP_COUNT)
            return;
        acc = '0;
        for (i = 0; i < fsw_pkg::TAP_COUNT; i++)
            acc = acc + fsw_pkg::ACC_W'(tap_coef[i]) * fsw_pkg::ACC_W'(sample_hist[i]);
        for (i = 0; i + 1 < fsw_pkg::TAP_COUNT; i++)
            sample_hist[i] = sample_hist[i + 1];
        samples_held = fsw_pkg::TAP_COUNT - 1;
        pending_sums.push_back(acc);
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [fsw_pkg::SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return fsw_pkg::SAMPLE_W'($urandom_range(0, 15) - 8);
            default: return fsw_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [fsw_pkg::OUT_TDATA_W-1:0] want,
                                   input logic [fsw_pkg::OUT_TDATA_W-1:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Sample transaction: optional gap, offer, wait for acceptance.
    // Called and returns on a rising edge.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [fsw_pkg::SAMPLE_W-1:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        compute_fir_sum(x);
        sent_count++;
    endtask

    // coefficient write; valid is left high for a following write
    task automatic write_reg(input logic [fsw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fsw_pkg::COEF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < fsw_pkg::NUM_COEFS)
            tap_coef[idx] = value;
        cfg_writes++;
    endtask

    // quiet both request channels and let every result come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_all_coefs(input logic [fsw_pkg::COEF_W-1:0] value);
        int i;
        for (i = 0; i < fsw_pkg::NUM_COEFS; i++)
            write_reg(fsw_pkg::CFG_IDX_W'(REG_COEF_0 + i), value);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, or a long hold when one is requested
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_ready_gen
        int stall;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall_left--;
        end
        else
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall_left = stall - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest predicted sum
    always @(posedge clk)
    begin : check_filtered_out
        logic [fsw_pkg::OUT_TDATA_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_sums.size() == 0)
                report_mismatch("unexpected result", '0, m_axis_tdata);
            else
            begin
                want = '0;
                want[fsw_pkg::ACC_W-1:0] = pending_sums.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch("filtered_out", want, m_axis_tdata);
                checked_count++;
            end
        end
    end

    // stop a hung run: no transaction of any kind for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // coefficients are zero out of reset; the eighth sample gives a zero sum
    task automatic test_fill_from_reset();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(SAMPLE_MAX);
        drain_results();
    endtask

    // largest positive and most negative sums
    task automatic test_extreme_sums();
        int i;
        write_all_coefs(COEF_MIN);
        cfg_valid <= 1'b0;
        for (i = 0; i < fsw_pkg::TAP_COUNT; i++)
            send_sample(SAMPLE_MIN);
        drain_results();
        write_all_coefs(COEF_MAX);
        cfg_valid <= 1'b0;
        send_sample(SAMPLE_MIN);
        drain_results();
    endtask

    // distinct taps and a lone pulse show which tap meets which sample
    task automatic test_impulse_order();
        int i;
        for (i = 0; i < fsw_pkg::NUM_COEFS; i++)
            write_reg(fsw_pkg::CFG_IDX_W'(REG_COEF_0 + i),
                      fsw_pkg::COEF_W'((i + 1) << 8) ^ ((i % 2) ? '1 : '0));
        cfg_valid <= 1'b0;
        send_sample(16'h4000);
        for (i = 1; i < fsw_pkg::TAP_COUNT; i++)
            send_sample(16'h0000);
        drain_results();
    endtask

    // writes past the last coefficient must leave the taps alone
    task automatic test_unmapped_index();
        write_reg(REG_UNMAPPED_LO, COEF_MAX);
        write_reg(REG_UNMAPPED_HI, COEF_MIN);
        cfg_valid <= 1'b0;
        send_sample(SAMPLE_MAX);
        drain_results();
    endtask

    // hold the result side long enough for the core to stall its input
    task automatic test_output_backpressure();
        int i;
        no_idle       = 1'b1;
        rx_stall_left = LONG_HOLD;
        for (i = 0; i < 20; i++)
            send_sample(rand_sample());
        no_idle = 1'b0;
        drain_results();
    endtask

    // random sample streams under several coefficient sets
    task automatic test_random_phases();
        int phase;
        int i;
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1: write_all_coefs(COEF_MAX);
                2: write_all_coefs(COEF_MIN);
                4:
                begin
                    // only the oldest tap active
                    write_all_coefs('0);
                    write_reg(REG_COEF_0, fsw_pkg::COEF_W'($urandom));
                end
                default:
                    for (i = 0; i < fsw_pkg::NUM_COEFS; i++)
                        write_reg(fsw_pkg::CFG_IDX_W'(REG_COEF_0 + i),
                                  fsw_pkg::COEF_W'($urandom));
            endcase
            write_reg(fsw_pkg::CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                      fsw_pkg::COEF_W'($urandom));
            cfg_valid <= 1'b0;
            no_idle = (phase == 3);
            for (i = 0; i < PHASE_ITEMS; i++)
                send_sample(rand_sample());
            no_idle = 1'b0;
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        foreach (tap_coef[i])
            tap_coef[i] = '0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_from_reset();
        test_extreme_sums();
        test_impulse_order();
        test_unmapped_index();
        test_output_backpressure();
        test_random_phases();
        drain_results();

        $display("Covered %0d samples, %0d filtered sums checked, %0d coefficient writes",
                 sent_count, checked_count, cfg_writes);
        $display("Included extreme sums, tap ordering, unmapped writes and a long output hold");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
